/* src/snell_refraction_direction_assert.svh */
// Assertion macros for the refraction block and its checker.
// Expects clk and rst in the scope of each use.
`ifndef SNELL_REFRACTION_DIRECTION_ASSERT_SVH
`define SNELL_REFRACTION_DIRECTION_ASSERT_SVH

// same-cycle implication
`define SRD_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define SRD_ASSERT_NXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

/* src/srd_pkg.sv */
// Shared widths and types of the refraction pipeline.
// No dependencies.
`default_nettype none

package srd_pkg;

  localparam int unsigned VEC_W     = 16;  // Q2.14 vector component
  localparam int unsigned IDX_W     = 16;  // Q3.13 index
  localparam int unsigned NF_W      = VEC_W + 1;  // negated component
  localparam int unsigned PROD_W    = 2 * VEC_W;
  localparam int unsigned DOT_W     = PROD_W + 2;
  localparam int unsigned CRS_W     = PROD_W + 1;
  localparam int unsigned CMAG_W    = PROD_W - 1;
  localparam int unsigned SQ_W      = 2 * CMAG_W;
  localparam int unsigned SQS_W     = SQ_W + 2;
  localparam int unsigned COS_W     = PROD_W;
  localparam int unsigned S_TDATA_W = 6 * VEC_W + 2 * IDX_W;
  localparam int unsigned M_TDATA_W = 3 * VEC_W;
  localparam int unsigned M_TUSER_W = 1;

  typedef logic [VEC_W-1:0] comp_t;

  typedef struct packed {
    comp_t [2:0] n;
    comp_t [2:0] d;
    logic        eq;
  } ray_t;

endpackage

`default_nettype wire

/* src/srd_mul.sv */
// Two-stage unsigned multiplier, operands split in halves.
// Uses srd_pkg.
`default_nettype none

module srd_mul #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 32
) (
  input  logic            clk,
  input  logic            en,
  input  logic [AW-1:0]   a,
  input  logic [BW-1:0]   b,
  output logic [AW+BW-1:0] p
);
  import srd_pkg::*;

  localparam int unsigned PW = AW + BW;
  localparam int unsigned AL = (AW + 1) / 2;
  localparam int unsigned AU = AW - AL;
  localparam int unsigned BL = (BW + 1) / 2;
  localparam int unsigned BU = BW - BL;

  logic [AL+BL-1:0] p_ll;
  logic [AL+BU-1:0] p_lu;
  logic [AU+BL-1:0] p_ul;
  logic [AU+BU-1:0] p_uu;

  always_ff @(posedge clk) begin
    if (en) begin
      p_ll <= a[AL-1:0] * b[BL-1:0];
      p_lu <= a[AL-1:0] * b[BW-1:BL];
      p_ul <= a[AW-1:AL] * b[BL-1:0];
      p_uu <= a[AW-1:AL] * b[BW-1:BL];
      p    <= PW'(p_ll) + (PW'(p_lu) << BL) + (PW'(p_ul) << AL)
              + (PW'(p_uu) << (AL + BL));
    end
  end

endmodule

`default_nettype wire

/* src/srd_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Quotient = floor(num * 2^FB / den). Uses srd_pkg.
`default_nettype none

module srd_div #(
  parameter int unsigned NW = 16,
  parameter int unsigned FB = 14
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NW-1:0]    num,
  input  logic [NW-1:0]    den,
  output logic [NW+FB-1:0] quo
);
  import srd_pkg::*;

  localparam int unsigned QW = NW + FB;

  logic [NW-1:0] rem_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [NW-1:0] nsh_q [QW];
  logic [NW-1:0] den_q [QW];

  logic [NW-1:0] prem [QW];
  logic [QW-1:0] pquo [QW];
  logic [NW-1:0] pnum [QW];
  logic [NW-1:0] pden [QW];
  logic [NW:0]   trial [QW];
  logic [NW:0]   diff [QW];
  logic          ge [QW];

  always_comb begin
    prem[0] = '0;
    pquo[0] = '0;
    pnum[0] = num;
    pden[0] = den;
    for (int j = 1; j < QW; j++) begin
      prem[j] = rem_q[j-1];
      pquo[j] = quo_q[j-1];
      pnum[j] = nsh_q[j-1];
      pden[j] = den_q[j-1];
    end
    for (int j = 0; j < QW; j++) begin
      trial[j] = {prem[j], pnum[j][NW-1]};
      diff[j]  = trial[j] - {1'b0, pden[j]};
      ge[j]    = trial[j] >= {1'b0, pden[j]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < QW; j++) begin
        rem_q[j] <= ge[j] ? diff[j][NW-1:0] : trial[j][NW-1:0];
        quo_q[j] <= {pquo[j][QW-2:0], ge[j]};
        nsh_q[j] <= pnum[j] << 1;  // zeros feed the fraction bits
        den_q[j] <= pden[j];
      end
    end
  end

  assign quo = quo_q[QW-1];

endmodule

`default_nettype wire

/* src/srd_sqrt.sv */
// Pipelined integer square root, one root bit per stage.
// root = floor(sqrt(rad)). Uses srd_pkg.
`default_nettype none

module srd_sqrt #(
  parameter int unsigned RN = 15
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RN-1:0] rad,
  output logic [RN-1:0]   root
);
  import srd_pkg::*;

  logic [RN:0]     rem_q  [RN];
  logic [RN-1:0]   root_q [RN];
  logic [2*RN-1:0] rsh_q  [RN];

  logic [RN:0]     prem  [RN];
  logic [RN-1:0]   proot [RN];
  logic [2*RN-1:0] prad  [RN];
  logic [RN+2:0]   trial [RN];
  logic [RN+2:0]   tsub  [RN];
  logic [RN+2:0]   diff  [RN];
  logic            ge    [RN];

  always_comb begin
    prem[0]  = '0;
    proot[0] = '0;
    prad[0]  = rad;
    for (int j = 1; j < RN; j++) begin
      prem[j]  = rem_q[j-1];
      proot[j] = root_q[j-1];
      prad[j]  = rsh_q[j-1];
    end
    for (int j = 0; j < RN; j++) begin
      trial[j] = {prem[j], prad[j][2*RN-1:2*RN-2]};
      tsub[j]  = {1'b0, proot[j], 2'b01};
      diff[j]  = trial[j] - tsub[j];
      ge[j]    = trial[j] >= tsub[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < RN; j++) begin
        rem_q[j]  <= ge[j] ? diff[j][RN:0] : trial[j][RN:0];
        root_q[j] <= {proot[j][RN-2:0], ge[j]};
        rsh_q[j]  <= prad[j] << 2;
      end
    end
  end

  assign root = root_q[RN-1];

endmodule

`default_nettype wire

/* src/snell_refraction_direction.sv */
// Snell's-law refraction direction, streaming pipeline, top level.
// Uses srd_pkg, srd_div, srd_mul, srd_sqrt.
//
//  channel | dir | beat contents (lowest bits first)
//  --------+-----+---------------------------------------------------------
//  s_*     | in  | normal x/y/z, dir x/y/z (Q2.14), index_from, index_to
//  m_*     | out | tdata: out x/y/z (Q2.14); tuser: total_reflection
//
// One beat accepted per cycle while the skid register is empty; independent rays overlap in the pipeline.
// Most of the pipeline is the divider (16+FRAC_BITS bit stages) followed by
// the root (FRAC_BITS+1 stages).
// Synchronous reset clears the valid bits and the skid stage only; the input
// is refused while rst is high.
// All stages advance together while the skid stage is empty; a stalled
// output beat parks in the skid register and the pipeline holds, losing nothing.
`default_nettype none

module snell_refraction_direction #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // normal_x, normal_y, normal_z, dir_x, dir_y, dir_z, index_from, index_to
  input  logic [srd_pkg::S_TDATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // out_x, out_y, out_z
  output logic [srd_pkg::M_TDATA_W-1:0]  m_tdata,
  // total_reflection
  output logic [srd_pkg::M_TUSER_W-1:0]  m_tuser
);
  import srd_pkg::*;

  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned BW   = IDX_W + F;           // ratio b
  localparam int unsigned TB   = 1 + BW;              // cycle b is ready
  localparam int unsigned B2W  = 2 * BW - F;          // b^2
  localparam int unsigned S2W  = SQS_W - 2 * F;       // sin^2
  localparam int unsigned PW   = B2W + S2W;           // b^2 * sin^2
  localparam int unsigned PXW  = (PW > 3 * F) ? PW : 3 * F + 1;
  localparam int unsigned QW   = BW + COS_W;          // b * cos
  localparam int unsigned BCW  = QW - 2 * F;
  localparam int unsigned RN   = F + 1;               // root digits
  localparam int unsigned RADW = 2 * F + 1;
  localparam int unsigned TS   = TB + 5;              // radicand ready
  localparam int unsigned TR   = TS + RN;             // root ready
  localparam int unsigned LAT  = TR + 3;
  localparam int unsigned AW   = ((RN > BCW) ? RN : BCW) + 1;
  localparam int unsigned PAW  = AW + NF_W;
  localparam int unsigned PBW  = BW + 1 + VEC_W;
  localparam int unsigned SW   = ((PAW > PBW) ? PAW : PBW) + 1;
  localparam int unsigned RAYD = TR + 2;
  localparam int unsigned NEGD = TR - 1;
  localparam int unsigned COSD = TB;
  localparam int unsigned S2D  = TB - 2;
  localparam int unsigned BD   = TR - TB + 1;
  localparam int unsigned BCD  = RN + 1;
  localparam int unsigned TRD  = RN + 3;

  localparam logic [RADW-1:0] RAD_ONE  = RADW'(1) << (2 * F);
  localparam logic [SW-1:0]   RND_HALF = SW'(1) << (F - 1);

  // flow control: whole pipe moves while the skid register is free
  logic en;
  logic skid_v;
  assign en       = !skid_v;
  assign s_tready = en && !rst;

  logic [LAT-1:0] vp;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else if (en) begin
      vp <= {vp[LAT-2:0], s_tvalid};
    end
  end

  // stage 1: capture the beat; ray fields ride along to the end
  logic [IDX_W-1:0] in_fi;
  logic [IDX_W-1:0] in_ti;
  logic [IDX_W-1:0] fi_a;
  logic [IDX_W-1:0] ti_a;
  ray_t             sd [RAYD];

  assign in_fi = s_tdata[6*VEC_W +: IDX_W];
  assign in_ti = s_tdata[6*VEC_W+IDX_W +: IDX_W];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sd[0].n[i] <= s_tdata[VEC_W*i +: VEC_W];
        sd[0].d[i] <= s_tdata[VEC_W*(3+i) +: VEC_W];
      end
      sd[0].eq <= (in_fi == in_ti);
      fi_a     <= in_fi;
      // a zero index_to counts as one LSB
      ti_a     <= (in_ti == '0) ? IDX_W'(1) : in_ti;
      for (int k = 1; k < RAYD; k++) begin
        sd[k] <= sd[k-1];
      end
    end
  end

  // b = index_from / index_to, ready at TB
  logic [BW-1:0] div_q;

  srd_div #(
    .NW (IDX_W),
    .FB (F)
  ) u_div (
    .clk (clk),
    .en  (en),
    .num (fi_a),
    .den (ti_a),
    .quo (div_q)
  );

  // stage 2: component products for N.D and N x D
  logic signed [PROD_W-1:0] pd [3];
  logic signed [PROD_W-1:0] px [6];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pd[i] <= $signed(sd[0].n[i]) * $signed(sd[0].d[i]);
      end
      px[0] <= $signed(sd[0].n[1]) * $signed(sd[0].d[2]);
      px[1] <= $signed(sd[0].n[2]) * $signed(sd[0].d[1]);
      px[2] <= $signed(sd[0].n[2]) * $signed(sd[0].d[0]);
      px[3] <= $signed(sd[0].n[0]) * $signed(sd[0].d[2]);
      px[4] <= $signed(sd[0].n[0]) * $signed(sd[0].d[1]);
      px[5] <= $signed(sd[0].n[1]) * $signed(sd[0].d[0]);
    end
  end

  // stage 3: dot sign and magnitude, cross magnitudes
  // (flipping N only negates the cross product, so its magnitude is kept)
  logic signed [DOT_W-1:0] dot;
  logic [DOT_W-1:0]        dot_mag;
  logic signed [CRS_W-1:0] crs [3];
  logic [CRS_W-1:0]        crs_mag [3];
  logic                    negd [NEGD];
  logic [COS_W-1:0]        cosd [COSD];
  logic [CMAG_W-1:0]       cm [3];

  always_comb begin
    dot     = DOT_W'(pd[0]) + DOT_W'(pd[1]) + DOT_W'(pd[2]);
    dot_mag = dot[DOT_W-1] ? DOT_W'(-dot) : DOT_W'(dot);
    for (int i = 0; i < 3; i++) begin
      crs[i]     = CRS_W'(px[2*i]) - CRS_W'(px[2*i+1]);
      crs_mag[i] = crs[i][CRS_W-1] ? CRS_W'(-crs[i]) : CRS_W'(crs[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      negd[0] <= dot[DOT_W-1];
      cosd[0] <= dot_mag[COS_W-1:0];
      for (int i = 0; i < 3; i++) begin
        cm[i] <= crs_mag[i][CMAG_W-1:0];
      end
      for (int k = 1; k < NEGD; k++) begin
        negd[k] <= negd[k-1];
      end
      for (int k = 1; k < COSD; k++) begin
        cosd[k] <= cosd[k-1];
      end
    end
  end

  // stages 4-5: squares, then sin^2 with 2F fraction bits
  logic [SQ_W-1:0]  sq [3];
  logic [SQS_W-1:0] sq_sum;
  logic [S2W-1:0]   s2d [S2D];

  assign sq_sum = SQS_W'(sq[0]) + SQS_W'(sq[1]) + SQS_W'(sq[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= cm[i] * cm[i];
      end
      s2d[0] <= sq_sum[SQS_W-1:2*F];
      for (int k = 1; k < S2D; k++) begin
        s2d[k] <= s2d[k-1];
      end
    end
  end

  // b delay line, bd[k] holds cycle TB+1+k
  logic [BW-1:0] bd [BD];

  always_ff @(posedge clk) begin
    if (en) begin
      bd[0] <= div_q;
      for (int k = 1; k < BD; k++) begin
        bd[k] <= bd[k-1];
      end
    end
  end

  // b^2 at TB+2, then b^2*sin^2 and b*cos at TB+4
  logic [2*BW-1:0] p_bb;
  logic [PW-1:0]   p_k;
  logic [QW-1:0]   p_bc;

  srd_mul #(
    .AW (BW),
    .BW (BW)
  ) u_mul_bb (
    .clk (clk),
    .en  (en),
    .a   (div_q),
    .b   (div_q),
    .p   (p_bb)
  );

  srd_mul #(
    .AW (B2W),
    .BW (S2W)
  ) u_mul_k (
    .clk (clk),
    .en  (en),
    .a   (p_bb[2*BW-1:F]),
    .b   (s2d[S2D-1]),
    .p   (p_k)
  );

  srd_mul #(
    .AW (BW),
    .BW (COS_W)
  ) u_mul_bc (
    .clk (clk),
    .en  (en),
    .a   (bd[1]),
    .b   (cosd[COSD-1]),
    .p   (p_bc)
  );

  // stage TS: total reflection test and radicand 1 - k
  logic [PXW-1:0]  pkx;
  logic [RADW-1:0] rad;
  logic            trd [TRD];
  logic [BCW-1:0]  bcd [BCD];

  assign pkx = PXW'(p_k);

  always_ff @(posedge clk) begin
    if (en) begin
      trd[0] <= |pkx[PXW-1:3*F];
      rad    <= RAD_ONE - RADW'(pkx[3*F-1:F]);
      bcd[0] <= p_bc[QW-1:2*F];
      for (int k = 1; k < TRD; k++) begin
        trd[k] <= trd[k-1];
      end
      for (int k = 1; k < BCD; k++) begin
        bcd[k] <= bcd[k-1];
      end
    end
  end

  logic [RN-1:0] sq_root;

  srd_sqrt #(
    .RN (RN)
  ) u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  ({1'b0, rad}),
    .root (sq_root)
  );

  // TR+1: a = root - b*cos; TR+2: a*N and b*D with N facing the ray
  logic signed [AW-1:0]   a;
  logic signed [NF_W-1:0] nf_raw [3];
  logic signed [NF_W-1:0] nf [3];
  logic signed [PAW-1:0]  pa [3];
  logic signed [PBW-1:0]  pb [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nf_raw[i] = NF_W'($signed(sd[TR].n[i]));
      nf[i]     = negd[NEGD-1] ? -nf_raw[i] : nf_raw[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a <= $signed(AW'(sq_root)) - $signed(AW'(bcd[BCD-1]));
      for (int i = 0; i < 3; i++) begin
        pa[i] <= a * nf[i];
        pb[i] <= $signed({1'b0, bd[BD-1]}) * $signed(sd[TR].d[i]);
      end
    end
  end

  // TR+3: round half up, saturate, pick pass-through, reflection (zero) or the refracted result
  logic signed [SW-1:0]  sum [3];
  logic signed [SW-1:0]  shr [3];
  logic [VEC_W-1:0]      sat [3];
  logic [M_TDATA_W-1:0]  res;
  logic [M_TDATA_W-1:0]  pin_data;
  logic                  pin_tr;
  logic                  pin_v;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = SW'(pa[i]) + SW'(pb[i]) + $signed(RND_HALF);
      shr[i] = sum[i] >>> F;
      if (!shr[i][SW-1] && |shr[i][SW-2:VEC_W-1]) begin
        sat[i] = {1'b0, {(VEC_W-1){1'b1}}};
      end else if (shr[i][SW-1] && !(&shr[i][SW-2:VEC_W-1])) begin
        sat[i] = {1'b1, {(VEC_W-1){1'b0}}};
      end else begin
        sat[i] = shr[i][VEC_W-1:0];
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (sd[RAYD-1].eq) begin
        res[VEC_W*i +: VEC_W] = sd[RAYD-1].d[i];
      end else if (trd[TRD-1]) begin
        res[VEC_W*i +: VEC_W] = '0;
      end else begin
        res[VEC_W*i +: VEC_W] = sat[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pin_data <= res;
      pin_tr   <= trd[TRD-1] && !sd[RAYD-1].eq;
    end
  end

  assign pin_v = vp[LAT-1] && en;

  // output register plus skid register
  logic [M_TDATA_W-1:0] skid_data;
  logic                 skid_tr;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      skid_v   <= 1'b0;
    end else begin
      if (!m_tvalid || m_tready) begin
        m_tvalid <= skid_v || pin_v;
        skid_v   <= 1'b0;
      end else if (pin_v) begin
        skid_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      m_tdata    <= skid_v ? skid_data : pin_data;
      m_tuser[0] <= skid_v ? skid_tr : pin_tr;
    end else if (pin_v) begin
      skid_data <= pin_data;
      skid_tr   <= pin_tr;
    end
  end

endmodule

`default_nettype wire

/* src/srd_chk.sv */
// Port-level checker for the refraction block, bound to the top level.
// Uses srd_pkg and snell_refraction_direction_assert.svh.
`default_nettype none
`include "snell_refraction_direction_assert.svh"

module srd_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [srd_pkg::S_TDATA_W-1:0]  s_tdata,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [srd_pkg::M_TDATA_W-1:0]  m_tdata,
  input logic [srd_pkg::M_TUSER_W-1:0]  m_tuser
);
  import srd_pkg::*;

  // stalled output beat stays and holds
  `SRD_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "output beat dropped")
  `SRD_ASSERT_NXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "stalled beat changed")

  // reflection beats carry a zero direction
  `SRD_ASSERT_IMP(a_tr_zero, m_tvalid && m_tuser[0], m_tdata == '0, "reflection with nonzero data")

  // input only stalls when a beat is parked behind the output
  `SRD_ASSERT_IMP(a_stall_cause, !s_tready, m_tvalid, "input stalled with empty output")

endmodule

bind snell_refraction_direction srd_chk u_srd_chk (.*);

`default_nettype wire
